### design/prime_sieve_engine_assert.svh
// ---------------------------------------------------------------------------
// Prime sieve engine assertion macros
// Concurrent checks, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef PRIME_SIEVE_ENGINE_ASSERT_SVH
`define PRIME_SIEVE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

`define PSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prime sieve engine: assertion failed");

`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prime sieve engine: assertion failed");

`else

`define PSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/pse_pkg.sv
// ---------------------------------------------------------------------------
// Prime sieve engine package
// Shared widths, constants and the response struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pse_pkg;

  localparam int MAX_NUMBER_DEF  = 1048576;
  localparam int LIMIT_W         = 20;
  localparam int PRIME_W         = 20;
  localparam int UPPER_LIMIT_RST = 1048575;

  // one bitmap row holds the odd numbers of a block of 16
  localparam int ROW_SHIFT = 4;
  localparam int ROW_W     = 1 << (ROW_SHIFT - 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic               valid;
    logic [PRIME_W-1:0] prime;
    logic               exhausted;
  } rsp_t;

endpackage

### design/pse_bitmap.sv
// ---------------------------------------------------------------------------
// Prime sieve bitmap
// Row memory of maybe-prime flags for odd numbers, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_bitmap #(
  parameter int AW = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [pse_pkg::ROW_W-1:0]  wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [pse_pkg::ROW_W-1:0]  rd_data
);

  logic [pse_pkg::ROW_W-1:0] mem [0:(1 << AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/pse_step_unit.sv
// ---------------------------------------------------------------------------
// Prime sieve step unit
// Shared adder with a compare against the active limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_step_unit #(
  parameter int SW = 22
) (
  input  logic [SW-1:0] op_a,
  input  logic [SW-1:0] op_b,
  input  logic [SW-1:0] limit,
  output logic [SW-1:0] sum,
  output logic          in_range
);

  assign sum      = op_a + op_b;
  assign in_range = (sum <= limit);

endmodule

### design/pse_ctrl.sv
// ---------------------------------------------------------------------------
// Prime sieve sequencer
// Clears the bitmap, walks odd candidates and strikes out their multiples.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_ctrl #(
  parameter int MAX_NUMBER = pse_pkg::MAX_NUMBER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pse_pkg::LIMIT_W-1:0] cfg_limit,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        req_restart,
  output pse_pkg::rsp_t               rsp,
  input  logic                        rsp_ready
);

  localparam int NW = $clog2(MAX_NUMBER);
  localparam int SW = NW + 2;
  localparam int AW = (NW > pse_pkg::ROW_SHIFT) ? NW - pse_pkg::ROW_SHIFT : 1;
  localparam int BW = pse_pkg::ROW_SHIFT - 1;
  localparam int CW = (NW > pse_pkg::LIMIT_W) ? NW : pse_pkg::LIMIT_W;
  localparam logic [NW-1:0] LIM_RST = NW'((pse_pkg::UPPER_LIMIT_RST > MAX_NUMBER - 1) ?
                                          MAX_NUMBER - 1 : pse_pkg::UPPER_LIMIT_RST);

  typedef enum logic [9:0] {
    ST_CLEAR      = 10'b00_0000_0001,
    ST_IDLE       = 10'b00_0000_0010,
    ST_START      = 10'b00_0000_0100,
    ST_SRCH_RD    = 10'b00_0000_1000,
    ST_SRCH_CHK   = 10'b00_0001_0000,
    ST_SQUARE     = 10'b00_0010_0000,
    ST_MARK_FIRST = 10'b00_0100_0000,
    ST_MARK_RD    = 10'b00_1000_0000,
    ST_MARK_WR    = 10'b01_0000_0000,
    ST_RESP       = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              pend_r, pend_nxt;
  logic [NW-1:0]     lim_r, lim_nxt;
  logic [NW-1:0]     cursor_r, cursor_nxt;
  logic [NW-1:0]     cand_r, cand_nxt;
  logic [NW-1:0]     mult_r, mult_nxt;
  logic [2*NW-1:0]   sq_r;
  logic [NW-1:0]     res_prime_r, res_prime_nxt;
  logic              res_exh_r, res_exh_nxt;

  logic [CW-1:0]     cfg_ext;
  logic [CW-1:0]     cap;
  logic [NW-1:0]     lim_sat;

  logic [SW-1:0]     op_a, op_b, step_sum;
  logic              step_ok;

  logic                       bm_wr_en;
  logic [AW-1:0]              bm_wr_addr;
  logic [pse_pkg::ROW_W-1:0]  bm_wr_data;
  logic [AW-1:0]              bm_rd_addr;
  logic [pse_pkg::ROW_W-1:0]  bm_rd_data;

  assign cfg_ext = CW'(cfg_limit);
  assign cap     = CW'(MAX_NUMBER - 1);
  assign lim_sat = NW'((cfg_ext > cap) ? cap : cfg_ext);

  pse_bitmap #(
    .AW (AW)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  pse_step_unit #(
    .SW (SW)
  ) u_step (
    .op_a     (op_a),
    .op_b     (op_b),
    .limit    (SW'(lim_r)),
    .sum      (step_sum),
    .in_range (step_ok)
  );

  // operand select for the shared adder
  always_comb begin
    unique case (state_r)
      ST_START: begin
        op_a = SW'(cursor_r);
        op_b = (cursor_r == NW'(2)) ? SW'(1) : SW'(2);
      end
      ST_MARK_WR: begin
        op_a = SW'(mult_r);
        op_b = SW'(cand_r) << 1;
      end
      default: begin
        op_a = SW'(cand_r);
        op_b = SW'(2);
      end
    endcase
  end

  always_comb begin
    bm_rd_addr = (state_r == ST_MARK_RD) ? AW'(mult_r >> pse_pkg::ROW_SHIFT) :
                                           AW'(cand_r >> pse_pkg::ROW_SHIFT);
    bm_wr_en   = 1'b0;
    bm_wr_addr = AW'(mult_r >> pse_pkg::ROW_SHIFT);
    bm_wr_data = bm_rd_data & ~(pse_pkg::ROW_W'(1) << mult_r[BW:1]);
    if (state_r == ST_CLEAR) begin
      bm_wr_en   = 1'b1;
      bm_wr_addr = clr_r;
      bm_wr_data = '1;
    end else if (state_r == ST_MARK_WR) begin
      bm_wr_en   = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pend_nxt      = pend_r;
    lim_nxt       = lim_r;
    cursor_nxt    = cursor_r;
    cand_nxt      = cand_r;
    mult_nxt      = mult_r;
    res_prime_nxt = res_prime_r;
    res_exh_nxt   = res_exh_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = pend_r ? ST_START : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req_restart) begin
            lim_nxt    = lim_sat;
            cursor_nxt = '0;
            clr_nxt    = '0;
            pend_nxt   = 1'b1;
            state_nxt  = ST_CLEAR;
          end else begin
            state_nxt  = ST_START;
          end
        end
      end
      ST_START: begin
        if (cursor_r < NW'(2)) begin
          state_nxt = ST_RESP;
          if (lim_r >= NW'(2)) begin
            cursor_nxt    = NW'(2);
            res_prime_nxt = NW'(2);
            res_exh_nxt   = 1'b0;
          end else begin
            cursor_nxt    = lim_r;
            res_prime_nxt = '0;
            res_exh_nxt   = 1'b1;
          end
        end else if (step_ok) begin
          cand_nxt  = NW'(step_sum);
          state_nxt = ST_SRCH_RD;
        end else begin
          cursor_nxt    = (lim_r > NW'(2)) ? lim_r : NW'(2);
          res_prime_nxt = '0;
          res_exh_nxt   = 1'b1;
          state_nxt     = ST_RESP;
        end
      end
      ST_SRCH_RD: begin
        state_nxt = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (bm_rd_data[cand_r[BW:1]]) begin
          state_nxt = ST_SQUARE;
        end else if (step_ok) begin
          cand_nxt  = NW'(step_sum);
          state_nxt = ST_SRCH_RD;
        end else begin
          cursor_nxt    = (lim_r > NW'(2)) ? lim_r : NW'(2);
          res_prime_nxt = '0;
          res_exh_nxt   = 1'b1;
          state_nxt     = ST_RESP;
        end
      end
      ST_SQUARE: begin
        state_nxt = ST_MARK_FIRST;
      end
      ST_MARK_FIRST: begin
        if (sq_r <= (2*NW)'(lim_r)) begin
          mult_nxt  = NW'(sq_r);
          state_nxt = ST_MARK_RD;
        end else begin
          cursor_nxt    = cand_r;
          res_prime_nxt = cand_r;
          res_exh_nxt   = 1'b0;
          state_nxt     = ST_RESP;
        end
      end
      ST_MARK_RD: begin
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        if (step_ok) begin
          mult_nxt  = NW'(step_sum);
          state_nxt = ST_MARK_RD;
        end else begin
          cursor_nxt    = cand_r;
          res_prime_nxt = cand_r;
          res_exh_nxt   = 1'b0;
          state_nxt     = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      lim_r    <= LIM_RST;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      lim_r    <= lim_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    mult_r      <= mult_nxt;
    res_prime_r <= res_prime_nxt;
    res_exh_r   <= res_exh_nxt;
    sq_r        <= cand_r * cand_r;
  end

  assign req_ready     = (state_r == ST_IDLE);
  assign rsp.valid     = (state_r == ST_RESP);
  assign rsp.prime     = pse_pkg::PRIME_W'(res_prime_r);
  assign rsp.exhausted = res_exh_r;

endmodule

### design/prime_sieve_engine.sv
// ---------------------------------------------------------------------------
// Prime sieve engine
// Incremental Sieve of Eratosthenes: each request word returns the next prime.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  in_      | slave     | tdata[0] restart
//  out_     | master    | tdata[19:0] prime_value, tdata[20] exhausted
//  cfg_     | write     | wr_data upper_limit, taken on wr_en
//
//  Reset and every restart clear the bitmap one row of 8 odd numbers per cycle,
//  over 2^clog2(MAX_NUMBER)/16 rows, at least 2 (65536 at the default); no words taken.
//  A request passes start, a read and a check per odd candidate scanned, the square
//  and its compare, a read-modify-write per multiple struck, then response and idle.
//  One word is in work at a time; a finished word waits in the output register
//  while the next request is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prime_sieve_engine_assert.svh"

module prime_sieve_engine #(
  parameter int MAX_NUMBER = pse_pkg::MAX_NUMBER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pse_pkg::LIMIT_W-1:0]     cfg_wr_data,   // upper_limit
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pse_pkg::IN_TDATA_W-1:0]  in_tdata,      // [0] restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pse_pkg::OUT_TDATA_W-1:0] out_tdata      // [19:0] prime_value, [20] exhausted
);

  logic [pse_pkg::LIMIT_W-1:0] upper_limit_r;
  logic                        out_valid_r;
  logic [pse_pkg::PRIME_W-1:0] out_prime_r;
  logic                        out_exh_r;
  pse_pkg::rsp_t               rsp;
  logic                        rsp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= pse_pkg::LIMIT_W'(pse_pkg::UPPER_LIMIT_RST);
    end else if (cfg_wr_en) begin
      upper_limit_r <= cfg_wr_data;
    end
  end

  pse_ctrl #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_limit   (upper_limit_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_restart (in_tdata[0]),
    .rsp         (rsp),
    .rsp_ready   (rsp_ready)
  );

  // load a new word once the held one is gone
  assign rsp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.valid && rsp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_ready) begin
      out_prime_r <= rsp.prime;
      out_exh_r   <= rsp.exhausted;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pse_pkg::OUT_TDATA_W'({out_exh_r, out_prime_r});

  `PSE_ASSERT_IMPL(a_exh_zero, clk, rst_n, out_valid_r && out_exh_r, out_prime_r == '0)
  `PSE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PSE_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp.valid && !rsp_ready, rsp.valid)

endmodule

### verif/prime_sieve_engine_checker.sv
// ---------------------------------------------------------------------------
// Prime sieve engine checker
// Watches the config, request and answer channels, predicts the next prime
// from its own bitmap copy and compares each answer word with the oldest
// prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_engine_checker #(
  parameter int SIEVE_SIZE = pse_pkg::MAX_NUMBER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pse_pkg::LIMIT_W-1:0]     cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pse_pkg::IN_TDATA_W-1:0]  in_tdata,
  output int unsigned                     words_answered,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pse_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int unsigned                     failures
);

  typedef struct packed {
    logic [pse_pkg::PRIME_W-1:0] prime;
    logic                        exhausted;
  } sieve_answer_t;

  bit            maybe_prime [SIEVE_SIZE];
  int unsigned   last_prime;
  int unsigned   limit_reg;
  int unsigned   live_limit;
  sieve_answer_t answer_q[$];
  int unsigned   answered;
  int unsigned   error_total;

  function automatic void clear_sieve();
    for (int k = 0; k < SIEVE_SIZE; k++) begin
      maybe_prime[k] = (k < 4) || (k % 2 == 1);
    end
    last_prime = 0;
    live_limit = (limit_reg > SIEVE_SIZE - 1) ? SIEVE_SIZE - 1 : limit_reg;
  endfunction

  function automatic sieve_answer_t next_answer(input logic restart);
    sieve_answer_t    ans;
    int unsigned      cand;
    longint unsigned  mult;
    bit               found;
    ans.prime     = '0;
    ans.exhausted = 1'b1;
    found         = 1'b0;
    if (restart) clear_sieve();
    if (last_prime < 2) begin
      if (live_limit >= 2) begin
        last_prime    = 2;
        ans.prime     = 2;
        ans.exhausted = 1'b0;
      end else begin
        last_prime = live_limit;
      end
      return ans;
    end
    cand = (last_prime == 2) ? 3 : last_prime + 2;
    while (!found && cand <= live_limit) begin
      if (maybe_prime[cand]) begin
        // strike odd multiples from the square up
        for (mult = 64'(cand) * cand; mult <= live_limit; mult += 2 * 64'(cand)) begin
          maybe_prime[mult] = 1'b0;
        end
        last_prime    = cand;
        ans.prime     = cand[pse_pkg::PRIME_W-1:0];
        ans.exhausted = 1'b0;
        found         = 1'b1;
      end else begin
        cand += 2;
      end
    end
    // park the cursor at the limit so later requests stay exhausted
    if (!found) last_prime = (live_limit > 2) ? live_limit : 2;
    return ans;
  endfunction

  always @(posedge clk) begin
    sieve_answer_t got;
    sieve_answer_t want;
    if (!rst_n) begin
      limit_reg = pse_pkg::UPPER_LIMIT_RST;
      clear_sieve();
      answer_q.delete();
      answered    = 0;
      error_total = 0;
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (in_tvalid && in_tready) answer_q = {answer_q, next_answer(in_tdata[0])};
      if (out_tvalid && out_tready) begin
        got.prime     = out_tdata[pse_pkg::PRIME_W-1:0];
        got.exhausted = out_tdata[pse_pkg::PRIME_W];
        answered++;
        if (answer_q.size() == 0) begin
          error_total++;
          $display("%0t: unexpected answer word, expected none, got prime %0d exhausted %0b",
                   $time, got.prime, got.exhausted);
        end else begin
          want = answer_q.pop_front();
          if (got.prime !== want.prime) begin
            error_total++;
            $display("%0t: prime_value expected %0d, got %0d", $time, want.prime, got.prime);
          end
          if (got.exhausted !== want.exhausted) begin
            error_total++;
            $display("%0t: exhausted expected %0b, got %0b",
                     $time, want.exhausted, got.exhausted);
          end
        end
      end
    end
    words_answered <= answered;
    // words still owed an answer count against the run
    failures       <= error_total + answer_q.size();
  end

endmodule

### verif/prime_sieve_engine_test.sv
// ---------------------------------------------------------------------------
// Prime sieve engine testbench
// Drives request words and upper_limit writes into a reduced-size sieve:
// a directed walk over tiny, saturated and changed limits, then random
// restart/continue sequences under four pacing modes. The checker beside
// the block predicts every answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_engine_test;

  // small bitmap keeps each clearing pass at 256 rows
  localparam int SIEVE_SIZE     = 4096;
  localparam int TOTAL_WORDS    = 650;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 200;
  localparam logic [pse_pkg::LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

  typedef enum int {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pacing_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [pse_pkg::LIMIT_W-1:0]     cfg_wr_data = '0;
  logic                            in_tvalid   = 1'b0;
  logic [pse_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                            out_tready  = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [pse_pkg::OUT_TDATA_W-1:0] out_tdata;

  int unsigned words_sent    = 0;
  int unsigned restarts_sent = 0;
  int unsigned limits_set    = 0;
  int unsigned send_gap_pct  = 0;
  int unsigned stall_pct     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned words_answered;
  int unsigned failures;

  prime_sieve_engine #(
    .MAX_NUMBER (SIEVE_SIZE)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  prime_sieve_engine_checker #(
    .SIEVE_SIZE (SIEVE_SIZE)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .words_answered (words_answered),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .failures       (failures)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("prime_sieve_engine: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_pacing(input pacing_t mode);
    unique case (mode)
      PACE_FREE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      PACE_SENDER_IDLE: begin
        send_gap_pct = 72;
        stall_pct    = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_gap_pct = 0;
        stall_pct    = 72;
      end
      default: begin
        send_gap_pct = 27;
        stall_pct    = 27;
      end
    endcase
  endtask

  task automatic send_request(input logic restart);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(pse_pkg::IN_TDATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (words_answered != words_sent) @(posedge clk);
  endtask

  // write only with nothing in flight
  task automatic set_limit(input int unsigned value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pse_pkg::LIMIT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limits_set++;
  endtask

  task automatic send_run(input logic first_restart, input int unsigned length);
    send_request(first_restart);
    repeat (length) begin
      if (words_sent < TOTAL_WORDS) send_request($urandom_range(99) < 6);
    end
  endtask

  function automatic int unsigned pick_limit();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return $urandom_range(1);
    if (roll < 12) return $urandom_range(LIMIT_ALL_ONES, SIEVE_SIZE);
    if (roll < 22) return $urandom_range(SIEVE_SIZE - 1, 1000);
    return $urandom_range(300, 2);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned runs;
    phase = 0;
    set_pacing(PACE_FREE);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // continue straight out of reset, then restart at the saturated reset limit
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    // limits below two: exhausted at once
    set_limit(0);
    send_request(1'b1);
    send_request(1'b0);
    set_limit(1);
    send_request(1'b1);
    set_limit(2);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    set_limit(3);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // new limit holds off until the next restart
    set_limit(9);
    send_request(1'b0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    set_limit(LIMIT_ALL_ONES);
    send_request(1'b1);
    send_request(1'b0);

    while (words_sent < TOTAL_WORDS) begin
      set_limit(pick_limit());
      set_pacing(pacing_t'(phase % 4));
      runs = $urandom_range(4, 2);
      for (int r = 0; r < runs && words_sent < TOTAL_WORDS; r++) begin
        send_run((r != 0) || ($urandom_range(99) < 80), $urandom_range(45));
      end
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d request words, %0d of them restarts, over %0d limit writes",
             words_sent, restarts_sent, limits_set);
    $display("pacing: free flow, sender gaps, receiver stalls and both mixed");
    if (failures == 0) begin
      $display("prime_sieve_engine: match");
    end else begin
      $display("prime_sieve_engine: mismatch");
    end
    $finish;
  end

endmodule
